FILE: rtl/park_transform_dq_macros.svh
// Assertion macros used by the top level of the park transform RTL.
`ifndef PARK_TRANSFORM_DQ_MACROS_SVH
`define PARK_TRANSFORM_DQ_MACROS_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge out of reset.
`define PTDQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that implies another in the next cycle.
`define PTDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PTDQ_ASSERT_ALWAYS(lbl, cond, msg)
`define PTDQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/ptdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_pkg
// Shared types, constants and fixed-point helpers of the park transform.
// ----------------------------------------------------------------------------
package ptdq_pkg;

  // Q2.62 constants of the sine and cosine series.
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam int unsigned TaylorTerms = 11;

  // Pipeline depth of one series cell and of the whole sine and cosine unit.
  localparam int unsigned CellLat = 4;
  localparam int unsigned TrigLat = CellLat * TaylorTerms + 5;

  // State handed from one series cell to the next.
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic [2:0]  oct;
  } cell_t;

  // Signed trig values as magnitude and sign.
  typedef struct packed {
    logic [63:0] s_mag;
    logic        s_neg;
    logic [63:0] c_mag;
    logic        c_neg;
  } trig_t;

  // Four 32 by 32 partial products of a 64 by 64 multiply.
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } part_t;

  // First half of a wide multiply: the partial products only.
  function automatic part_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    part_t p;
    p.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    p.lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    p.hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    p.hh = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return p;
  endfunction

  // Second half of a wide multiply: the full 128-bit product.
  function automatic logic [127:0] mul_sum(input part_t p);
    return 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ptdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_cell
// One Horner step of the sine and cosine series, pipelined.
// ----------------------------------------------------------------------------
module ptdq_cell #(
  parameter int unsigned K = 1
) (
  input  wire              clk,
  input  wire              en,
  input  ptdq_pkg::cell_t  d,
  output ptdq_pkg::cell_t  q
);
  import ptdq_pkg::*;

  localparam int unsigned DivS = (2 * K) * (2 * K + 1);
  localparam int unsigned DivC = (2 * K - 1) * (2 * K);
  localparam int unsigned ShS  = 62 + $clog2(DivS);
  localparam int unsigned ShC  = 62 + $clog2(DivC);
  // Rounded-up reciprocals; exact floor division for dividends below 2^62.
  localparam logic [63:0] MagS =
    64'(((128'd1 << ShS) + 128'(DivS) - 128'd1) / 128'(DivS));
  localparam logic [63:0] MagC =
    64'(((128'd1 << ShC) + 128'(DivC) - 128'd1) / 128'(DivC));

  cell_t        s1;
  cell_t        s2;
  cell_t        s3;
  part_t        ps1;
  part_t        pc1;
  part_t        ps3;
  part_t        pc3;
  logic [63:0]  ys2;
  logic [63:0]  yc2;
  logic [127:0] sum_s1;
  logic [127:0] sum_c1;
  logic [127:0] sum_s3;
  logic [127:0] sum_c3;
  cell_t        q_next;

  // Each term is one minus x squared times the inner term over its factorial step.
  always_comb begin
    sum_s1    = mul_sum(ps1);
    sum_c1    = mul_sum(pc1);
    sum_s3    = mul_sum(ps3);
    sum_c3    = mul_sum(pc3);
    q_next    = s3;
    q_next.ts = ONE_Q62 - 64'(sum_s3 >> ShS);
    q_next.tc = ONE_Q62 - 64'(sum_c3 >> ShC);
  end

  // Partial products, product sums, reciprocal products, then the new terms.
  always_ff @(posedge clk) begin
    if (en) begin
      ps1 <= mul_parts(d.x2, d.ts);
      pc1 <= mul_parts(d.x2, d.tc);
      s1  <= d;
      ys2 <= sum_s1[125:62];
      yc2 <= sum_c1[125:62];
      s2  <= s1;
      ps3 <= mul_parts(ys2, MagS);
      pc3 <= mul_parts(yc2, MagC);
      s3  <= s2;
      q   <= q_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptdq_trig.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_trig
// Pipelined sine and cosine: octant reduction, a chain of series cells and
// octant reconstruction.
// ----------------------------------------------------------------------------
module ptdq_trig #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                    clk,
  input  wire                    en,
  input  wire [ANGLE_BITS-1:0]   ang,
  output ptdq_pkg::trig_t        res
);
  import ptdq_pkg::*;

  localparam int unsigned OctShift = ANGLE_BITS - 3;
  localparam logic [OctShift:0] OctSize = (OctShift + 1)'(1) << OctShift;

  logic [2:0]        oct_in;
  logic [OctShift:0] r;
  logic [127:0]      rp;
  logic [63:0]       x1;
  logic [2:0]        oct1;
  part_t             xx_p;
  logic [63:0]       x_d;
  logic [2:0]        oct_d;
  logic [127:0]      xx_sum;
  cell_t             head;
  cell_t             chain [TaylorTerms+1];
  part_t             sx_p;
  logic [63:0]       tc_f;
  logic [2:0]        oct_f;
  logic [127:0]      sx_sum;
  logic [63:0]       sx;
  logic [63:0]       sp;
  logic [63:0]       cp;
  trig_t             res_next;

  // Reduce the angle to an octant and scale it to radians.
  always_comb begin
    oct_in = ang[ANGLE_BITS-1 -: 3];
    r      = {1'b0, ang[OctShift-1:0]};
    if (oct_in[0]) begin
      r = OctSize - r;
    end
    rp = 128'(r) * {64'd0, PI_Q62};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= 64'(rp >> (ANGLE_BITS - 1));
      oct1 <= oct_in;
    end
  end

  // Square the reduced angle; the partial products are registered here and summed into the seed.
  always_ff @(posedge clk) begin
    if (en) begin
      xx_p  <= mul_parts(x1, x1);
      x_d   <= x1;
      oct_d <= oct1;
    end
  end

  // Seed both series.
  always_comb begin
    xx_sum   = mul_sum(xx_p);
    head.x   = x_d;
    head.x2  = xx_sum[125:62];
    head.ts  = ONE_Q62;
    head.tc  = ONE_Q62;
    head.oct = oct_d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= head;
    end
  end

  // Series cells from the highest term down to the first.
  for (genvar i = 0; i < TaylorTerms; i++) begin : g_cell
    ptdq_cell #(.K(TaylorTerms - i)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  // Partial products of the sine term.
  always_ff @(posedge clk) begin
    if (en) begin
      sx_p  <= mul_parts(chain[TaylorTerms].x, chain[TaylorTerms].ts);
      tc_f  <= chain[TaylorTerms].tc;
      oct_f <= chain[TaylorTerms].oct;
    end
  end

  // Rebuild signed sine and cosine from the octant.
  always_comb begin
    sx_sum = mul_sum(sx_p);
    sx     = sx_sum[125:62];
    if (oct_f[0]) begin
      sp = tc_f;
      cp = sx;
    end else begin
      sp = sx;
      cp = tc_f;
    end
    case (oct_f[2:1])
      2'd0: res_next = '{s_mag: sp, s_neg: 1'b0, c_mag: cp, c_neg: 1'b0};
      2'd1: res_next = '{s_mag: cp, s_neg: 1'b0, c_mag: sp, c_neg: 1'b1};
      2'd2: res_next = '{s_mag: sp, s_neg: 1'b1, c_mag: cp, c_neg: 1'b1};
      default: res_next = '{s_mag: cp, s_neg: 1'b1, c_mag: sp, c_neg: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptdq_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptdq_mul
// Signed amplitude times a trig value, rounded to Q1.15 and saturated.
// ----------------------------------------------------------------------------
module ptdq_mul #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire signed [SAMPLE_BITS-1:0] amp,
  input  wire        [63:0]            tmag,
  input  wire                          tneg,
  output logic signed [SAMPLE_BITS-1:0] prod
);

  localparam int unsigned PW = SAMPLE_BITS + 64;
  localparam logic signed [SAMPLE_BITS+1:0] SatMax = (SAMPLE_BITS + 2)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SAMPLE_BITS+1:0] SatMin = -(SAMPLE_BITS + 2)'(1 << (SAMPLE_BITS - 1));

  logic [SAMPLE_BITS-1:0]          mag;
  logic [PW-1:0]                   p;
  logic [SAMPLE_BITS+1:0]          rmag;
  logic                            neg;
  logic signed [SAMPLE_BITS+1:0]   v;

  // Round the magnitude half up at bit 62, then apply the sign and clamp.
  always_comb begin
    mag  = amp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-amp) : SAMPLE_BITS'(amp);
    p    = PW'(mag) * PW'(tmag) + (PW'(1) << 61);
    rmag = (SAMPLE_BITS + 2)'(p >> 62);
    neg  = amp[SAMPLE_BITS-1] ^ tneg;
    v    = neg ? -$signed(rmag) : $signed(rmag);
    if (v > SatMax) begin
      v = SatMax;
    end else if (v < SatMin) begin
      v = SatMin;
    end
    prod = SAMPLE_BITS'(v);
  end

endmodule
`default_nettype wire

FILE: rtl/park_transform_dq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// park_transform_dq
// Park transform between three-phase values and the dq frame.
// ----------------------------------------------------------------------------
// Input beats carry func, three signed samples and an angle on in_valid and
// in_stall; result beats leave on out_valid and out_stall. Forward mode gives
// d, q and zero; inverse mode gives the three phase values.
// One beat is taken every cycle unless a waiting result is stalled. Each beat
// passes the sine and cosine pipeline (octant reduction, squaring, 11 series
// cells, the sine partial products and the octant rebuild), then the rounded
// products and the sums.
// Reset empties the pipeline; no result is pending afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised in the same cycle, so no beat is lost.
// ----------------------------------------------------------------------------
module park_transform_dq #(
  parameter int unsigned ANGLE_BITS  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           func,
  input  wire signed [SAMPLE_BITS-1:0]  in_first,
  input  wire signed [SAMPLE_BITS-1:0]  in_second,
  input  wire signed [SAMPLE_BITS-1:0]  in_third,
  input  wire        [ANGLE_BITS-1:0]   angle,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [SAMPLE_BITS+1:0] out_first,
  output logic signed [SAMPLE_BITS+1:0] out_second,
  output logic signed [SAMPLE_BITS+1:0] out_third
);
  import ptdq_pkg::*;
  `include "park_transform_dq_macros.svh"

  localparam int unsigned Depth   = TrigLat + 2;
  localparam logic [ANGLE_BITS-1:0] AngMask = '1;
  localparam logic [ANGLE_BITS-1:0] OffA = ANGLE_BITS'((64'(AngMask) * 2) / 3);
  localparam logic [ANGLE_BITS-1:0] OffB = ANGLE_BITS'(64'(AngMask) / 3);
  localparam int unsigned SW = SAMPLE_BITS + 3;
  localparam int unsigned RecN = 2 * SW;
  localparam logic [RecN-1:0] Recip = RecN'(((64'd1 << RecN) / 3) + 1);

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] a1;
    logic [SAMPLE_BITS-1:0] a2;
    logic [SAMPLE_BITS-1:0] a3;
  } pay_t;

  logic                          en;
  logic [Depth-1:0]              vld;
  pay_t                          pay [TrigLat];
  logic [ANGLE_BITS-1:0]         angs [3];
  trig_t                         tr [3];
  logic [SAMPLE_BITS-1:0]        amp_c [3];
  logic [SAMPLE_BITS-1:0]        amp_s [3];
  logic signed [SAMPLE_BITS-1:0] pc_n [3];
  logic signed [SAMPLE_BITS-1:0] ps_n [3];
  logic signed [SAMPLE_BITS-1:0] pc [3];
  logic signed [SAMPLE_BITS-1:0] ps [3];
  logic                          func_p;
  logic signed [SW-1:0]          sc2;
  logic signed [SW-1:0]          ss2;
  logic signed [SAMPLE_BITS+1:0] d_q;
  logic signed [SAMPLE_BITS+1:0] q_q;
  logic signed [SAMPLE_BITS+1:0] r1;
  logic signed [SAMPLE_BITS+1:0] r2;
  logic signed [SAMPLE_BITS+1:0] r3;

  // Signed divide by three, truncating toward zero.
  function automatic logic signed [SAMPLE_BITS+1:0] div3(input logic signed [SW-1:0] t);
    logic [SW-1:0]        m;
    logic [SW+RecN-1:0]   p;
    logic [SAMPLE_BITS+1:0] qm;
    m  = t[SW-1] ? SW'(-t) : SW'(t);
    p  = (SW + RecN)'(m) * (SW + RecN)'(Recip);
    qm = (SAMPLE_BITS + 2)'(p >> RecN);
    return t[SW-1] ? -$signed(qm) : $signed(qm);
  endfunction

  // The pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Payload delay line aligned with the trig pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= '{func: func, a1: in_first, a2: in_second, a3: in_third};
      for (int i = 1; i < TrigLat; i++) begin
        pay[i] <= pay[i-1];
      end
    end
  end

  // Phase angles.
  assign angs[0] = angle;
  assign angs[1] = angle + OffA;
  assign angs[2] = angle + OffB;

  for (genvar g = 0; g < 3; g++) begin : g_phase
    ptdq_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
      .clk (clk),
      .en  (en),
      .ang (angs[g]),
      .res (tr[g])
    );

    ptdq_mul #(.SAMPLE_BITS(SAMPLE_BITS)) u_mul_c (
      .amp  (amp_c[g]),
      .tmag (tr[g].c_mag),
      .tneg (tr[g].c_neg),
      .prod (pc_n[g])
    );

    ptdq_mul #(.SAMPLE_BITS(SAMPLE_BITS)) u_mul_s (
      .amp  (amp_s[g]),
      .tmag (tr[g].s_mag),
      .tneg (tr[g].s_neg),
      .prod (ps_n[g])
    );
  end

  // Amplitude selection per mode.
  always_comb begin
    if (pay[TrigLat-1].func) begin
      for (int i = 0; i < 3; i++) begin
        amp_c[i] = pay[TrigLat-1].a1;
        amp_s[i] = pay[TrigLat-1].a2;
      end
    end else begin
      amp_c[0] = pay[TrigLat-1].a1;
      amp_c[1] = pay[TrigLat-1].a2;
      amp_c[2] = pay[TrigLat-1].a3;
      amp_s    = amp_c;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (en) begin
      pc     <= pc_n;
      ps     <= ps_n;
      func_p <= pay[TrigLat-1].func;
    end
  end

  // Sums and scaling.
  always_comb begin
    sc2 = (SW'(pc[0]) + SW'(pc[1]) + SW'(pc[2])) <<< 1;
    ss2 = (SW'(ps[0]) + SW'(ps[1]) + SW'(ps[2])) <<< 1;
    d_q = div3(sc2);
    q_q = -div3(ss2);
    r1  = (SAMPLE_BITS + 2)'(pc[0]) - (SAMPLE_BITS + 2)'(ps[0]);
    r2  = (SAMPLE_BITS + 2)'(pc[1]) - (SAMPLE_BITS + 2)'(ps[1]);
    r3  = (SAMPLE_BITS + 2)'(pc[2]) - (SAMPLE_BITS + 2)'(ps[2]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_first  <= func_p ? r1 : d_q;
      out_second <= func_p ? r2 : q_q;
      out_third  <= func_p ? r3 : '0;
    end
  end

  `PTDQ_ASSERT_ALWAYS(a_stall_only_when_full, !in_stall || out_valid, "stall without a pending result")
  `PTDQ_ASSERT_NEXT(a_last_stage_delivers, vld[Depth-2] && en, out_valid, "result lost at output")
  `PTDQ_ASSERT_NEXT(a_forward_third_zero, vld[Depth-2] && en && !func_p, out_third == '0, "forward third not zero")

endmodule
`default_nettype wire
